FILE: hw/rtl/lrp_pkg.sv
package lrp_pkg;

	localparam int MAX_RULE_COUNT_DEF = 32;
	localparam int MAX_RULE_LEN_DEF   = 8;
	localparam int MAX_EXP_DEF        = 4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [5:0] RULE_COUNT_RST  = 6'd2;
	localparam logic [3:0] RULE_LENGTH_RST = 4'd8;

	typedef enum logic {
		REG_RULE_COUNT  = 1'b0,
		REG_RULE_LENGTH = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RULE  = 2'd1,
		OP_COPY  = 2'd2,
		OP_MARK  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] symbol;
		logic [4:0] rule_index;
		logic [2:0] rule_offset;
		logic [3:0] n_emit;
		logic       eop;
		logic       trunc;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hw/rtl/lrp_ifs.sv
interface lrp_stream_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] symbol;
	logic [4:0] rule_index;
	logic [2:0] rule_offset;
	logic       end_of_pass;

	modport source (
		output valid, command, symbol, rule_index, rule_offset, end_of_pass,
		input  ready
	);
	modport sink (
		input  valid, command, symbol, rule_index, rule_offset, end_of_pass,
		output ready
	);
endinterface

interface lrp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       empty_res;
	logic       last;
	logic       truncated;

	modport source (
		output valid, out_symbol, empty_res, last, truncated,
		input  ready
	);
	modport sink (
		input  valid, out_symbol, empty_res, last, truncated,
		output ready
	);
endinterface

FILE: hw/rtl/lrp_front.sv
module lrp_front #(
	parameter int MAX_RULE_COUNT = lrp_pkg::MAX_RULE_COUNT_DEF,
	parameter int MAX_RULE_LEN   = lrp_pkg::MAX_RULE_LEN_DEF,
	parameter int MAX_EXP        = lrp_pkg::MAX_EXP_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	lrp_stream_if.sink      stream,
	input  logic [5:0]      rule_count,
	input  logic [3:0]      rule_length,
	output logic            push,
	output lrp_pkg::entry_t push_entry,
	input  logic            q_ready
);
	import lrp_pkg::*;

	localparam int CW = $clog2(MAX_EXP + 1);

	logic [CW-1:0] emitted_q;
	logic          dropped_q;
	logic          accept;
	logic          is_rule;
	logic [3:0]    len_eff;
	logic [3:0]    needed;
	logic [CW-1:0] remaining;
	logic          short_fall;
	logic [3:0]    n_emit;
	logic          wr_ok;

	assign stream.ready = q_ready;
	assign accept = stream.valid && q_ready;

	always_comb begin
		is_rule    = (int'(stream.symbol) < int'(rule_count)) &&
			(int'(stream.symbol) < MAX_RULE_COUNT);
		len_eff    = (int'(rule_length) > MAX_RULE_LEN) ? 4'(MAX_RULE_LEN) : rule_length;
		needed     = is_rule ? len_eff : 4'd1;
		remaining  = CW'(MAX_EXP) - emitted_q;
		short_fall = CW'(needed) > remaining;
		n_emit     = short_fall ? remaining[3:0] : needed;
		wr_ok      = (int'(stream.rule_index) < MAX_RULE_COUNT) &&
			(int'(stream.rule_offset) < MAX_RULE_LEN);

		push_entry.symbol      = stream.symbol;
		push_entry.rule_index  = stream.rule_index;
		push_entry.rule_offset = stream.rule_offset;
		push_entry.n_emit      = n_emit;
		push_entry.eop         = stream.end_of_pass;
		push_entry.trunc       = dropped_q || short_fall;

		if (!stream.command) begin
			push_entry.op = OP_WRITE;
			push          = accept && wr_ok;
		end else if (n_emit == 4'd0) begin
			push_entry.op = OP_MARK;
			push          = accept && stream.end_of_pass;
		end else begin
			push_entry.op = is_rule ? OP_RULE : OP_COPY;
			push          = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q <= '0;
			dropped_q <= 1'b0;
		end else if (accept && stream.command) begin
			if (stream.end_of_pass) begin
				emitted_q <= '0;
				dropped_q <= 1'b0;
			end else begin
				emitted_q <= emitted_q + CW'(n_emit);
				dropped_q <= dropped_q || short_fall;
			end
		end
	end

endmodule

FILE: hw/rtl/lrp_queue.sv
module lrp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lrp_pkg::entry_t  push_entry,
	output logic             q_ready,
	output logic             head_valid,
	output lrp_pkg::entry_t  head,
	input  logic             pop,
	output lrp_pkg::q_stat_t status
);
	import lrp_pkg::*;

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign q_ready      = !status.full;
	assign head_valid   = !status.empty;
	assign head         = slots_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/lrp_back.sv
module lrp_back #(
	parameter int MAX_RULE_COUNT = lrp_pkg::MAX_RULE_COUNT_DEF,
	parameter int MAX_RULE_LEN   = lrp_pkg::MAX_RULE_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  lrp_pkg::entry_t head,
	output logic            pop,
	lrp_result_if.source    result
);
	import lrp_pkg::*;

	localparam int DEPTH = MAX_RULE_COUNT * MAX_RULE_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]    table_mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [3:0]    cnt_q;
	logic          out_v_q;
	logic          sel_mem_q;
	logic [7:0]    sym_q;
	logic          empty_q;
	logic          last_q;
	logic          trunc_q;
	logic          adv;
	logic          load;
	logic          mem_we;
	logic          mem_re;
	logic          final_sym;
	logic [7:0]    a_idx;
	logic [3:0]    a_off;
	logic [AW-1:0] addr;

	assign adv       = !out_v_q || result.ready;
	assign final_sym = (cnt_q == head.n_emit - 4'd1);

	always_comb begin
		pop    = 1'b0;
		load   = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (head_valid) begin
			unique case (head.op)
				OP_WRITE: begin
					mem_we = 1'b1;
					pop    = 1'b1;
				end
				OP_RULE: begin
					load   = adv;
					mem_re = adv;
					pop    = adv && final_sym;
				end
				OP_COPY, OP_MARK: begin
					load = adv;
					pop  = adv;
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		if (head.op == OP_WRITE) begin
			a_idx = {3'b000, head.rule_index};
			a_off = {1'b0, head.rule_offset};
		end else begin
			a_idx = head.symbol;
			a_off = cnt_q;
		end
		addr = AW'(32'(a_idx) * MAX_RULE_LEN + 32'(a_off));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[addr] <= head.symbol;
		end
		if (mem_re) begin
			rdata_q <= table_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sel_mem_q <= (head.op == OP_RULE);
			sym_q     <= (head.op == OP_MARK) ? 8'd0 : head.symbol;
			empty_q   <= (head.op == OP_MARK);
			last_q    <= head.eop && ((head.op != OP_RULE) || final_sym);
			trunc_q   <= head.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (mem_re) begin
				cnt_q <= final_sym ? 4'd0 : cnt_q + 4'd1;
			end
		end
	end

	assign result.valid      = out_v_q;
	assign result.out_symbol = sel_mem_q ? rdata_q : sym_q;
	assign result.empty_res  = empty_q;
	assign result.last       = last_q;
	assign result.truncated  = trunc_q;

endmodule

FILE: hw/rtl/lsystem_rewrite_pass_core.sv
// A rule-table write gives no word. A copied symbol, or the empty end-of-pass
// marker, gives one word. A rule symbol gives one word per emitted symbol, so
// up to rule_length words, because the back end reads one table entry per
// cycle while the output is not held, from the single read port of the rule
// table. A four-entry queue sits between the input side and the back end, so
// input words keep being taken while a rule expands and the queue has room.
// The single output register holds a word until it is taken, and while it
// waits the back end emits nothing more; only table writes still go through.
module lsystem_rewrite_pass_core #(
	parameter int MAX_RULE_COUNT = lrp_pkg::MAX_RULE_COUNT_DEF,
	parameter int MAX_RULE_LEN   = lrp_pkg::MAX_RULE_LEN_DEF,
	parameter int MAX_EXP        = lrp_pkg::MAX_EXP_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lrp_stream_if.sink                   stream,
	lrp_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lrp_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrp_pkg::PDATA_W-1:0]  pwdata,
	output logic [lrp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import lrp_pkg::*;

	logic       [5:0] rule_count_q;
	logic       [3:0] rule_length_q;
	reg_idx_t         reg_sel;
	logic             push;
	entry_t           push_entry;
	logic             q_ready;
	logic             head_valid;
	entry_t           head;
	logic             pop;
	q_stat_t          q_status;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q  <= RULE_COUNT_RST;
			rule_length_q <= RULE_LENGTH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_RULE_COUNT:  rule_count_q  <= pwdata[5:0];
				REG_RULE_LENGTH: rule_length_q <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_RULE_COUNT:  prdata = {26'd0, rule_count_q};
			REG_RULE_LENGTH: prdata = {28'd0, rule_length_q};
			default:         prdata = '0;
		endcase
	end

	lrp_front #(
		.MAX_RULE_COUNT(MAX_RULE_COUNT),
		.MAX_RULE_LEN  (MAX_RULE_LEN),
		.MAX_EXP       (MAX_EXP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.rule_count (rule_count_q),
		.rule_length(rule_length_q),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	lrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.q_ready   (q_ready),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.status    (q_status)
	);

	lrp_back #(
		.MAX_RULE_COUNT(MAX_RULE_COUNT),
		.MAX_RULE_LEN  (MAX_RULE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.empty_res |-> result.last && (result.out_symbol == 8'd0))
		else $error("marker word without last or with a symbol");

	a_word_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(head_valid))
		else $error("result word appeared with no queued entry");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !stream.ready)
		else $error("input taken while the queue is full");

endmodule
